// ----- rtl/core/rgbnv12_pkg.sv -----
package rgbnv12_pkg;

  // field widths
  localparam int ADDR_W = 25;
  localparam int COMP_W = 8;
  localparam int CFG_W  = 13;

  // frame size limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] RST_LINE_STRIDE  = 13'd640;

  // bt.601 limited-range coefficients
  localparam logic signed [16:0] CY_R = 17'sd66;
  localparam logic signed [16:0] CY_G = 17'sd129;
  localparam logic signed [16:0] CY_B = 17'sd25;
  localparam logic signed [16:0] CU_R = -17'sd38;
  localparam logic signed [16:0] CU_G = -17'sd74;
  localparam logic signed [16:0] CU_B = 17'sd112;
  localparam logic signed [16:0] CV_R = 17'sd112;
  localparam logic signed [16:0] CV_G = -17'sd94;
  localparam logic signed [16:0] CV_B = -17'sd18;
  localparam logic signed [16:0] ROUND_ADD = 17'sd128;
  localparam logic signed [9:0]  Y_OFFSET = 10'sd16;
  localparam logic signed [9:0]  C_OFFSET = 10'sd128;
  localparam logic signed [9:0]  BYTE_MAX = 10'sd255;

  typedef enum logic [1:0] {
    REG_INPUT_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_LINE_STRIDE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef struct packed {
    logic [COMP_W-1:0] comp_first;
    logic [COMP_W-1:0] comp_second;
    logic [COMP_W-1:0] comp_third;
  } pix_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [COMP_W-1:0] write_byte;
    plane_t            plane_kind;
    logic              last_of_pixel;
    logic              end_of_frame;
  } wr_t;

  typedef struct packed {
    reg_idx_t         reg_index;
    logic [CFG_W-1:0] reg_value;
  } cfg_req_t;

  typedef struct packed {
    logic             input_mode;
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    pix_t              pix;
    logic [ADDR_W-1:0] y_addr;
    logic [ADDR_W-1:0] c_addr;
    logic              chroma;
    logic              eof;
  } job_t;

  typedef struct packed {
    logic [COMP_W-1:0] y;
    logic [COMP_W-1:0] u;
    logic [COMP_W-1:0] v;
  } yuv_t;

  // floor shift by 8, add offset, clamp to 0..255
  function automatic logic [COMP_W-1:0] scale_clamp(input logic signed [16:0] sum,
                                                     input logic signed [9:0] offset);
    logic signed [9:0] t;
    logic [COMP_W-1:0] res;
    t = 10'(sum >>> 8) + offset;
    if (t < 10'sd0) begin
      res = '0;
    end else if (t > BYTE_MAX) begin
      res = '1;
    end else begin
      res = t[COMP_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/rgbnv12_if.sv -----
interface rgbnv12_pix_if;
  logic                valid;
  logic                ready;
  rgbnv12_pkg::pix_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rgbnv12_wr_if;
  logic                valid;
  logic                ready;
  rgbnv12_pkg::wr_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rgbnv12_cfg_if;
  logic                  valid;
  logic                  ready;
  rgbnv12_pkg::cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/rgb_or_yuv444_to_nv12.sv -----
// A pixel passes the stage register in rgbnv12_addr and the result registers in rgbnv12_ser before its first write.
// Throughput: one pixel per cycle on odd rows or columns while the write receiver keeps ready high;
//   a pixel that writes chroma needs three writes, Y, U and V, on the one-byte output port.
// Input is held off for the cycle after each register write and the first cycle after reset.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the raster counters and
//   loads the register defaults: RGB mode, 640 x 480, stride 640.
module rgb_or_yuv444_to_nv12 #(
  parameter int MAX_WIDTH  = rgbnv12_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbnv12_pkg::DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rgbnv12_cfg_if.sink          cfg_wr,
  rgbnv12_pix_if.sink          in_pix,
  rgbnv12_wr_if.source         out_wr
);

  rgbnv12_pkg::cfg_t cfg_r;
  logic              cfg_hold_r;
  logic              cfg_fire;

  logic              st_valid, st_take;
  rgbnv12_pkg::job_t st_job;
  rgbnv12_pkg::yuv_t yuv;

  // register file
  assign cfg_wr.ready = 1'b1;
  assign cfg_fire     = cfg_wr.valid && cfg_wr.ready;

  // hold input in the cycle after a register write so the registered chroma plane start catches up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_mode   <= 1'b0;
      cfg_r.frame_width  <= rgbnv12_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height <= rgbnv12_pkg::RST_FRAME_HEIGHT;
      cfg_r.line_stride  <= rgbnv12_pkg::RST_LINE_STRIDE;
      cfg_hold_r         <= 1'b1;
    end else begin
      cfg_hold_r <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_wr.data.reg_index)
          rgbnv12_pkg::REG_INPUT_MODE:   cfg_r.input_mode   <= cfg_wr.data.reg_value[0];
          rgbnv12_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wr.data.reg_value;
          rgbnv12_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wr.data.reg_value;
          rgbnv12_pkg::REG_LINE_STRIDE:  cfg_r.line_stride  <= cfg_wr.data.reg_value;
          default: ;
        endcase
      end
    end
  end

  // raster position and addresses
  rgbnv12_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .hold     (cfg_hold_r),
    .in_valid (in_pix.valid),
    .in_data  (in_pix.data),
    .in_ready (in_pix.ready),
    .st_valid (st_valid),
    .st_job   (st_job),
    .st_take  (st_take)
  );

  // color conversion
  rgbnv12_csc u_csc (
    .mode (st_job.mode),
    .pix  (st_job.pix),
    .yuv  (yuv)
  );

  // byte write sequencing
  rgbnv12_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid),
    .st_job    (st_job),
    .yuv       (yuv),
    .st_take   (st_take),
    .out_valid (out_wr.valid),
    .out_data  (out_wr.data),
    .out_ready (out_wr.ready)
  );

  // checks
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> !in_pix.ready)
    else $error("input accepted right after a register write");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr.valid && out_wr.data.end_of_frame |-> out_wr.data.last_of_pixel)
    else $error("end of frame on a write that does not end its pixel");

  a_u_then_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr.valid && out_wr.ready && (out_wr.data.plane_kind == rgbnv12_pkg::PLANE_U)
    |=> out_wr.valid && (out_wr.data.plane_kind == rgbnv12_pkg::PLANE_V))
    else $error("U write not followed by V write");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_wr.valid)
    else $error("write offered right after reset");

endmodule

// ----- rtl/core/rgbnv12_addr.sv -----
module rgbnv12_addr #(
  parameter int MAX_WIDTH  = rgbnv12_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbnv12_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rgbnv12_pkg::cfg_t  cfg,
  input  logic               hold,
  input  logic               in_valid,
  input  rgbnv12_pkg::pix_t  in_data,
  output logic               in_ready,
  output logic               st_valid,
  output rgbnv12_pkg::job_t  st_job,
  input  logic               st_take
);

  localparam int AW  = rgbnv12_pkg::ADDR_W;
  localparam int CFW = rgbnv12_pkg::CFG_W;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int DW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CMW = (DW > CW + 1) ? DW : CW + 1;
  localparam int CMH = (HW > RW + 1) ? HW : RW + 1;

  logic [DW-1:0] w_raw, eff_w, s_cl, eff_s;
  logic [HW-1:0] h_raw, eff_h;
  logic [AW-1:0] prod_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] luma_base_r, luma_base_nxt;
  logic [AW-1:0] chroma_base_r, chroma_base_nxt;

  logic              st_valid_r;
  rgbnv12_pkg::job_t st_job_r, job_nxt;

  logic           in_fire, frame_start, last_col, last_row, chroma;
  logic [CMW-1:0] col_inc;
  logic [CMH-1:0] row_inc;
  logic [AW-1:0]  lb, cb;

  // effective width and height: clamp, then force even
  always_comb begin
    if (cfg.frame_width < CFW'(2)) begin
      w_raw = DW'(2);
    end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
      w_raw = DW'(MAX_WIDTH);
    end else begin
      w_raw = DW'(cfg.frame_width);
    end
    eff_w = w_raw & ~DW'(1);
  end

  always_comb begin
    if (cfg.frame_height < CFW'(2)) begin
      h_raw = HW'(2);
    end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
      h_raw = HW'(MAX_HEIGHT);
    end else begin
      h_raw = HW'(cfg.frame_height);
    end
    eff_h = h_raw & ~HW'(1);
  end

  // effective stride: capped, then at least the width
  always_comb begin
    if (32'(cfg.line_stride) > 32'(MAX_WIDTH)) begin
      s_cl = DW'(MAX_WIDTH);
    end else begin
      s_cl = DW'(cfg.line_stride);
    end
    eff_s = (s_cl < eff_w) ? eff_w : s_cl;
  end

  // chroma plane start, stride times height
  always_ff @(posedge clk) begin
    prod_r <= AW'({{HW{1'b0}}, eff_s} * {{DW{1'b0}}, eff_h});
  end

  // handshake into the stage register
  assign in_ready = (!st_valid_r || st_take) && !hold;
  assign in_fire  = in_valid && in_ready;

  // position and base addresses for the arriving pixel
  always_comb begin
    frame_start = (col_r == '0) && (row_r == '0);
    lb          = frame_start ? '0 : luma_base_r;
    cb          = frame_start ? prod_r : chroma_base_r;
    chroma      = !row_r[0] && !col_r[0];
    col_inc     = CMW'(col_r) + CMW'(1);
    row_inc     = CMH'(row_r) + CMH'(1);
    last_col    = col_inc >= CMW'(eff_w);
    last_row    = row_inc >= CMH'(eff_h);

    job_nxt.mode   = cfg.input_mode;
    job_nxt.pix    = in_data;
    job_nxt.y_addr = lb + AW'(col_r);
    job_nxt.c_addr = cb + AW'(col_r);
    job_nxt.chroma = chroma;
    job_nxt.eof    = last_col && last_row;
  end

  // raster advance
  always_comb begin
    if (last_col) begin
      col_nxt         = '0;
      luma_base_nxt   = lb + AW'(eff_s);
      chroma_base_nxt = row_r[0] ? cb : cb + AW'(eff_s);
      row_nxt         = last_row ? '0 : row_r + RW'(1);
    end else begin
      col_nxt         = col_r + CW'(1);
      luma_base_nxt   = lb;
      chroma_base_nxt = cb;
      row_nxt         = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      luma_base_r   <= '0;
      chroma_base_r <= '0;
      st_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r         <= col_nxt;
        row_r         <= row_nxt;
        luma_base_r   <= luma_base_nxt;
        chroma_base_r <= chroma_base_nxt;
        st_valid_r    <= 1'b1;
      end else if (st_take) begin
        st_valid_r    <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_job_r <= job_nxt;
    end
  end

  assign st_valid = st_valid_r;
  assign st_job   = st_job_r;

endmodule

// ----- rtl/core/rgbnv12_csc.sv -----
module rgbnv12_csc (
  input  logic              mode,
  input  rgbnv12_pkg::pix_t pix,
  output rgbnv12_pkg::yuv_t yuv
);

  logic signed [16:0] rs, gs, bs;
  logic signed [16:0] y_sum, u_sum, v_sum;

  // weighted sums with rounding term
  always_comb begin
    rs    = $signed({9'd0, pix.comp_first});
    gs    = $signed({9'd0, pix.comp_second});
    bs    = $signed({9'd0, pix.comp_third});
    y_sum = rgbnv12_pkg::CY_R * rs + rgbnv12_pkg::CY_G * gs + rgbnv12_pkg::CY_B * bs
            + rgbnv12_pkg::ROUND_ADD;
    u_sum = rgbnv12_pkg::CU_R * rs + rgbnv12_pkg::CU_G * gs + rgbnv12_pkg::CU_B * bs
            + rgbnv12_pkg::ROUND_ADD;
    v_sum = rgbnv12_pkg::CV_R * rs + rgbnv12_pkg::CV_G * gs + rgbnv12_pkg::CV_B * bs
            + rgbnv12_pkg::ROUND_ADD;
  end

  // convert or pass through
  always_comb begin
    if (mode) begin
      yuv.y = pix.comp_first;
      yuv.u = pix.comp_second;
      yuv.v = pix.comp_third;
    end else begin
      yuv.y = rgbnv12_pkg::scale_clamp(y_sum, rgbnv12_pkg::Y_OFFSET);
      yuv.u = rgbnv12_pkg::scale_clamp(u_sum, rgbnv12_pkg::C_OFFSET);
      yuv.v = rgbnv12_pkg::scale_clamp(v_sum, rgbnv12_pkg::C_OFFSET);
    end
  end

endmodule

// ----- rtl/core/rgbnv12_ser.sv -----
module rgbnv12_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              st_valid,
  input  rgbnv12_pkg::job_t st_job,
  input  rgbnv12_pkg::yuv_t yuv,
  output logic              st_take,
  output logic              out_valid,
  output rgbnv12_pkg::wr_t  out_data,
  input  logic              out_ready
);

  localparam int AW = rgbnv12_pkg::ADDR_W;

  logic                 valid_r;
  rgbnv12_pkg::plane_t  idx_r;
  rgbnv12_pkg::yuv_t    yuv_r;
  logic [AW-1:0]        ya_r, ca_r;
  logic                 chroma_r, eof_r;
  logic                 out_fire, last_beat, done;

  // beat control
  assign out_fire  = valid_r && out_ready;
  assign last_beat = !chroma_r || (idx_r == rgbnv12_pkg::PLANE_V);
  assign done      = out_fire && last_beat;
  assign st_take   = st_valid && (!valid_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= rgbnv12_pkg::PLANE_Y;
    end else begin
      if (st_take) begin
        valid_r <= 1'b1;
        idx_r   <= rgbnv12_pkg::PLANE_Y;
      end else if (done) begin
        valid_r <= 1'b0;
      end else if (out_fire) begin
        idx_r   <= (idx_r == rgbnv12_pkg::PLANE_Y) ? rgbnv12_pkg::PLANE_U
                                                   : rgbnv12_pkg::PLANE_V;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (st_take) begin
      yuv_r    <= yuv;
      ya_r     <= st_job.y_addr;
      ca_r     <= st_job.c_addr;
      chroma_r <= st_job.chroma;
      eof_r    <= st_job.eof;
    end
  end

  // select the current write
  always_comb begin
    out_data.plane_kind = idx_r;
    unique case (idx_r)
      rgbnv12_pkg::PLANE_Y: begin
        out_data.write_address = ya_r;
        out_data.write_byte    = yuv_r.y;
        out_data.last_of_pixel = !chroma_r;
        out_data.end_of_frame  = !chroma_r && eof_r;
      end
      rgbnv12_pkg::PLANE_U: begin
        out_data.write_address = ca_r;
        out_data.write_byte    = yuv_r.u;
        out_data.last_of_pixel = 1'b0;
        out_data.end_of_frame  = 1'b0;
      end
      rgbnv12_pkg::PLANE_V: begin
        out_data.write_address = ca_r + AW'(1);
        out_data.write_byte    = yuv_r.v;
        out_data.last_of_pixel = 1'b1;
        out_data.end_of_frame  = eof_r;
      end
      default: begin
        out_data.write_address = ya_r;
        out_data.write_byte    = yuv_r.y;
        out_data.last_of_pixel = 1'b0;
        out_data.end_of_frame  = 1'b0;
      end
    endcase
  end

  assign out_valid = valid_r;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_W     = rgbnv12_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H     = rgbnv12_pkg::DEF_MAX_HEIGHT;
  localparam int ADDR_W    = rgbnv12_pkg::ADDR_W;
  localparam int COMP_W    = rgbnv12_pkg::COMP_W;
  localparam int CFG_W     = rgbnv12_pkg::CFG_W;
  localparam int CYCLE_CAP = 300000;
  localparam int DRAIN_GAP = 4;

  logic clk;
  logic rst_n;

  rgbnv12_cfg_if cfg_bus ();
  rgbnv12_pix_if pix_bus ();
  rgbnv12_wr_if  wr_bus ();

  rgb_or_yuv444_to_nv12 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_bus.sink),
    .in_pix (pix_bus.sink),
    .out_wr (wr_bus.source)
  );

  // shadow registers and raster state of the converter
  logic              cfg_mode;
  logic [CFG_W-1:0]  cfg_width;
  logic [CFG_W-1:0]  cfg_height;
  logic [CFG_W-1:0]  cfg_stride;
  int                col_cnt;
  int                row_cnt;
  logic [ADDR_W-1:0] luma_base;
  logic [ADDR_W-1:0] chroma_base;

  rgbnv12_pkg::wr_t pending_writes[$];
  int  error_cnt;
  int  cycle_cnt;
  int  hold_left;
  bit  calm;
  int  pixels_sent;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("%0t: run limit reached, %0d writes outstanding", $time,
               pending_writes.size());
      $display("rgb_or_yuv444_to_nv12 verification failed");
      $finish;
    end
  end

  // write receiver: random stalls, a counted hold-off when requested, or always ready while calm
  always @(negedge clk) begin
    if (hold_left > 0) begin
      wr_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (calm) begin
      wr_bus.ready <= 1'b1;
    end else begin
      wr_bus.ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  function automatic int eff_dim(int v, int mx);
    if (v < 2) v = 2;
    if (v > mx) v = mx;
    return v & ~1;
  endfunction

  function automatic logic [COMP_W-1:0] to_byte(int sum, int offset);
    int t;
    t = (sum >>> 8) + offset;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[COMP_W-1:0];
  endfunction

  // nv12 writes caused by one pixel, pushed in output order
  function automatic void predict_writes(rgbnv12_pkg::pix_t p);
    int w, h, s, r, g, b;
    logic [COMP_W-1:0] y, u, v;
    bit chroma, last_col, eof;
    rgbnv12_pkg::wr_t wr;
    w = eff_dim(int'(cfg_width), MAX_W);
    h = eff_dim(int'(cfg_height), MAX_H);
    s = int'(cfg_stride);
    if (s > MAX_W) s = MAX_W;
    if (s < w) s = w;
    if (col_cnt == 0 && row_cnt == 0) begin
      luma_base   = '0;
      chroma_base = ADDR_W'(s * h);
    end
    if (cfg_mode) begin
      y = p.comp_first;
      u = p.comp_second;
      v = p.comp_third;
    end else begin
      r = int'(p.comp_first);
      g = int'(p.comp_second);
      b = int'(p.comp_third);
      y = to_byte(66 * r + 129 * g + 25 * b + 128, 16);
      u = to_byte(-38 * r - 74 * g + 112 * b + 128, 128);
      v = to_byte(112 * r - 94 * g - 18 * b + 128, 128);
    end
    chroma   = (row_cnt % 2 == 0) && (col_cnt % 2 == 0);
    last_col = (col_cnt + 1 >= w);
    eof      = last_col && (row_cnt + 1 >= h);

    wr.write_address = luma_base + ADDR_W'(col_cnt);
    wr.write_byte    = y;
    wr.plane_kind    = rgbnv12_pkg::PLANE_Y;
    wr.last_of_pixel = !chroma;
    wr.end_of_frame  = !chroma && eof;
    pending_writes.push_back(wr);
    if (chroma) begin
      wr.write_address = chroma_base + ADDR_W'(col_cnt);
      wr.write_byte    = u;
      wr.plane_kind    = rgbnv12_pkg::PLANE_U;
      wr.last_of_pixel = 1'b0;
      wr.end_of_frame  = 1'b0;
      pending_writes.push_back(wr);
      wr.write_address = chroma_base + ADDR_W'(col_cnt + 1);
      wr.write_byte    = v;
      wr.plane_kind    = rgbnv12_pkg::PLANE_V;
      wr.last_of_pixel = 1'b1;
      wr.end_of_frame  = eof;
      pending_writes.push_back(wr);
    end

    // raster advance
    if (last_col) begin
      col_cnt   = 0;
      luma_base = luma_base + ADDR_W'(s);
      if (row_cnt % 2 == 0) chroma_base = chroma_base + ADDR_W'(s);
      if (row_cnt + 1 >= h) row_cnt = 0;
      else row_cnt++;
    end else begin
      col_cnt++;
    end
  endfunction

  // compare each accepted write with the oldest prediction
  always @(posedge clk) begin : check_writes
    rgbnv12_pkg::wr_t got;
    rgbnv12_pkg::wr_t want;
    if (rst_n && wr_bus.valid && wr_bus.ready) begin
      got = wr_bus.data;
      if (pending_writes.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected write, expected none, actual addr %0h byte %0h plane %0d",
                 $time, got.write_address, got.write_byte, got.plane_kind);
      end else begin
        want = pending_writes.pop_front();
        if (got.write_address !== want.write_address) begin
          error_cnt++;
          $display("%0t: write_address expected %0h actual %0h", $time,
                   want.write_address, got.write_address);
        end
        if (got.write_byte !== want.write_byte) begin
          error_cnt++;
          $display("%0t: write_byte expected %0h actual %0h", $time,
                   want.write_byte, got.write_byte);
        end
        if (got.plane_kind !== want.plane_kind) begin
          error_cnt++;
          $display("%0t: plane_kind expected %0d actual %0d", $time,
                   want.plane_kind, got.plane_kind);
        end
        if (got.last_of_pixel !== want.last_of_pixel) begin
          error_cnt++;
          $display("%0t: last_of_pixel expected %0b actual %0b", $time,
                   want.last_of_pixel, got.last_of_pixel);
        end
        if (got.end_of_frame !== want.end_of_frame) begin
          error_cnt++;
          $display("%0t: end_of_frame expected %0b actual %0b", $time,
                   want.end_of_frame, got.end_of_frame);
        end
      end
    end
  end

  // one pixel request; entered and left at a falling edge, valid left high
  task automatic send_pixel(input logic [COMP_W-1:0] a, input logic [COMP_W-1:0] b,
                            input logic [COMP_W-1:0] c);
    rgbnv12_pkg::pix_t p;
    p = '{comp_first: a, comp_second: b, comp_third: c};
    if (!calm && $urandom_range(0, 99) < 10) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.data  <= p;
    do @(posedge clk); while (!pix_bus.ready);
    predict_writes(p);
    pixels_sent++;
    @(negedge clk);
  endtask

  function automatic logic [COMP_W-1:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return COMP_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(rand_byte(), rand_byte(), rand_byte());
  endtask

  // stop offering and wait until every predicted write has come out
  task automatic drain();
    pix_bus.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // register write request; only called with the converter drained
  task automatic write_reg(input rgbnv12_pkg::reg_idx_t idx, input int value);
    logic [CFG_W-1:0] v;
    v = CFG_W'(value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= '{reg_index: idx, reg_value: v};
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      rgbnv12_pkg::REG_INPUT_MODE:   cfg_mode   = v[0];
      rgbnv12_pkg::REG_FRAME_WIDTH:  cfg_width  = v;
      rgbnv12_pkg::REG_FRAME_HEIGHT: cfg_height = v;
      rgbnv12_pkg::REG_LINE_STRIDE:  cfg_stride = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input int mode, input int w, input int h, input int s);
    write_reg(rgbnv12_pkg::REG_INPUT_MODE, mode);
    write_reg(rgbnv12_pkg::REG_FRAME_WIDTH, w);
    write_reg(rgbnv12_pkg::REG_FRAME_HEIGHT, h);
    write_reg(rgbnv12_pkg::REG_LINE_STRIDE, s);
  endtask

  // rgb conversion on byte extremes, 2x2 frames so end of frame shows up
  task automatic test_rgb_extremes();
    drain();
    set_frame(0, 2, 2, 2);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    drain();
  endtask

  // yuv444 passthrough with stride wider than the row
  task automatic test_yuv_passthrough();
    set_frame(1, 4, 2, 6);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h01, 8'h80, 8'h7f);
    send_pixel(8'hfe, 8'h55, 8'haa);
    send_random_pixels(4);
    drain();
  endtask

  // out-of-range width, height and stride values
  task automatic test_size_clamping();
    // below minimum: everything becomes 2
    set_frame(0, 0, 1, 0);
    send_random_pixels(4);
    drain();
    // odd width, oversized height and stride: chroma plane at its highest start, 4096 x 4096
    set_frame(1, 3, 8191, 8191);
    send_random_pixels(4);
    drain();
    // odd sizes rounded down, stride raised to the width
    set_frame(0, 7, 5, 1);
    send_random_pixels(24);
    drain();
  endtask

  // shrink the frame, the width while the column counter is past the new width
  task automatic test_midframe_resize();
    set_frame(0, 8191, 4, 8191);
    send_random_pixels(6);
    drain();
    write_reg(rgbnv12_pkg::REG_FRAME_WIDTH, 4);
    send_random_pixels(14);
    drain();
    write_reg(rgbnv12_pkg::REG_FRAME_HEIGHT, 2);
    write_reg(rgbnv12_pkg::REG_LINE_STRIDE, 5);
    send_random_pixels(10);
    drain();
  endtask

  // receiver held off while the sender keeps offering, then a stall-free stretch
  task automatic test_backpressure();
    set_frame(0, 6, 4, 8);
    calm = 1'b1;
    hold_left = 300;
    send_random_pixels(20);
    drain();
    send_random_pixels(20);
    calm = 1'b0;
    drain();
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1);
    if (r == 1) return $urandom_range(4097, 8191);
    if (r == 2) return 2 * $urandom_range(1, 7) + 1;
    return 2 * $urandom_range(1, 6);
  endfunction

  // random settings per phase, some registers left as they were
  task automatic test_random_frames();
    int w, s, target;
    target = pixels_sent + 25;
    while (pixels_sent < target) begin
      if ($urandom_range(0, 3) != 0) begin
        write_reg(rgbnv12_pkg::REG_INPUT_MODE, $urandom_range(0, 1));
      end
      w = pick_dim();
      if ($urandom_range(0, 3) != 0) write_reg(rgbnv12_pkg::REG_FRAME_WIDTH, w);
      if ($urandom_range(0, 3) != 0) write_reg(rgbnv12_pkg::REG_FRAME_HEIGHT, pick_dim());
      case ($urandom_range(0, 7))
        0: s = 0;
        1: s = 8191;
        default: s = eff_dim(w, MAX_W) + $urandom_range(0, 5);
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(rgbnv12_pkg::REG_LINE_STRIDE, s);
      send_random_pixels($urandom_range(8, 20));
      drain();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.data   = '0;
    pix_bus.valid  = 1'b0;
    pix_bus.data   = '0;
    wr_bus.ready   = 1'b0;
    error_cnt      = 0;
    cycle_cnt      = 0;
    hold_left      = 0;
    calm           = 1'b0;
    pixels_sent    = 0;
    // reset values of the converter
    cfg_mode    = 1'b0;
    cfg_width   = rgbnv12_pkg::RST_FRAME_WIDTH;
    cfg_height  = rgbnv12_pkg::RST_FRAME_HEIGHT;
    cfg_stride  = rgbnv12_pkg::RST_LINE_STRIDE;
    col_cnt     = 0;
    row_cnt     = 0;
    luma_base   = '0;
    chroma_base = ADDR_W'(640 * 480);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // a few pixels at the reset settings
    send_random_pixels(3);
    test_rgb_extremes();
    test_yuv_passthrough();
    test_size_clamping();
    test_midframe_resize();
    test_backpressure();
    test_random_frames();

    drain();
    repeat (10) @(posedge clk);
    if (error_cnt == 0) begin
      $display("rgb_or_yuv444_to_nv12 verification clean");
    end else begin
      $display("rgb_or_yuv444_to_nv12 verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rgbnv12_pkg.sv
rtl/core/rgbnv12_if.sv
rtl/core/rgbnv12_addr.sv
rtl/core/rgbnv12_csc.sv
rtl/core/rgbnv12_ser.sv
rtl/core/rgb_or_yuv444_to_nv12.sv
dv/testbench.sv
